// ===== hw/rtl/ackp_pkg.sv =====
`timescale 1ns / 1ps
package ackp_pkg;

  localparam int BLOCK_BYTES = 16;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam logic [1:0] KIND_PROCESS = 2'd0;
  localparam logic [1:0] KIND_SKIP    = 2'd1;
  localparam logic [1:0] KIND_SEEK    = 2'd2;

  localparam logic [3:0] REG_KEY_0  = 4'd0;
  localparam logic [3:0] REG_KEY_1  = 4'd1;
  localparam logic [3:0] REG_KEY_2  = 4'd2;
  localparam logic [3:0] REG_KEY_3  = 4'd3;
  localparam logic [3:0] REG_KEY_LN = 4'd4;
  localparam logic [3:0] REG_IV_HI  = 4'd5;
  localparam logic [3:0] REG_IV_LO  = 4'd6;
  localparam logic [3:0] REG_IV_LN  = 4'd7;

  typedef enum logic [1:0] {MODE_ZERO, MODE_RAW, MODE_KS} mode_t;
  typedef enum logic [1:0] {RND_FULL, RND_FINAL, RND_PASS} rnd_t;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  din;
    logic [3:0]  sel;
    logic        ok;
    logic [63:0] pos;
    logic [63:0] ctr;
  } item_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        ok;
    logic [63:0] pos;
  } res_t;

  typedef logic [14:0][127:0] rk_t;

  localparam logic [2047:0] SBOX_BITS = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
  };

  function automatic logic [7:0] sbox(input logic [7:0] x);
    return SBOX_BITS[2047 - 8 * int'(x) -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                             input rnd_t kind);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [127:0] r;
    for (int n = 0; n < 16; n++) b[n] = sbox(s[127 - 8 * n -: 8]);
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++) t[i + 4 * c] = b[i + 4 * ((c + i) % 4)];
    for (int c = 0; c < 4; c++) begin
      m[4*c]   = xtime(t[4*c]) ^ xtime(t[4*c+1]) ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      m[4*c+1] = t[4*c] ^ xtime(t[4*c+1]) ^ xtime(t[4*c+2]) ^ t[4*c+2] ^ t[4*c+3];
      m[4*c+2] = t[4*c] ^ t[4*c+1] ^ xtime(t[4*c+2]) ^ xtime(t[4*c+3]) ^ t[4*c+3];
      m[4*c+3] = xtime(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ xtime(t[4*c+3]);
    end
    for (int n = 0; n < 16; n++) begin
      case (kind)
        RND_FULL:  r[127 - 8 * n -: 8] = m[n] ^ rk[127 - 8 * n -: 8];
        RND_FINAL: r[127 - 8 * n -: 8] = t[n] ^ rk[127 - 8 * n -: 8];
        default:   r[127 - 8 * n -: 8] = s[127 - 8 * n -: 8];
      endcase
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/ackp_fifo.sv =====
`timescale 1ns / 1ps
module ackp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_r, rd_r;
  logic [AW:0]      cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (AW + 1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_r] <= wdata;
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      if (do_pop)  rd_r <= (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      cnt_r <= cnt_r + (AW + 1)'(do_push) - (AW + 1)'(do_pop);
    end
  end
endmodule

// ===== hw/rtl/ackp_key.sv =====
`timescale 1ns / 1ps
module ackp_key import ackp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         init,
  input  logic [255:0] key,
  input  logic [5:0]   key_length,
  output rk_t          rk,
  output logic [3:0]   nr,
  output logic         busy
);
  logic [59:0][31:0] w_r;
  logic [31:0]       win_r [8];
  logic [5:0]        i_r;
  logic [2:0]        ph_r;
  logic [7:0]        rc_r;
  logic              busy_r;
  logic [3:0]        nk;
  logic [31:0]       t, back, nw;

  always_comb begin
    if (key_length == 6'd32) nk = 4'd8;
    else if (key_length == 6'd24) nk = 4'd6;
    else nk = 4'd4;
  end

  assign nr   = nk + 4'd6;
  assign busy = busy_r;

  always_comb begin
    case (nk)
      4'd8:    back = win_r[0];
      4'd6:    back = win_r[2];
      default: back = win_r[4];
    endcase
    t = win_r[7];
    if (ph_r == 3'd0) t = sub_word({t[23:0], t[31:24]}) ^ {rc_r, 24'h0};
    else if (nk == 4'd8 && ph_r == 3'd4) t = sub_word(t);
    nw = back ^ t;
  end

  always_comb begin
    for (int r = 0; r < 15; r++) rk[r] = {w_r[4*r], w_r[4*r+1], w_r[4*r+2], w_r[4*r+3]};
  end

  always_ff @(posedge clk) begin
    if (init) begin
      for (int j = 0; j < 8; j++) w_r[j] <= key[255 - 32 * j -: 32];
      for (int j = 0; j < 8; j++) begin
        if (j >= 8 - int'(nk)) win_r[j] <= key[255 - 32 * (j - (8 - int'(nk))) -: 32];
        else win_r[j] <= '0;
      end
      i_r  <= 6'(nk);
      ph_r <= '0;
      rc_r <= 8'h01;
    end else if (busy_r) begin
      for (int j = 0; j < 60; j++) if (i_r == 6'(j)) w_r[j] <= nw;
      for (int j = 0; j < 7; j++) win_r[j] <= win_r[j+1];
      win_r[7] <= nw;
      i_r  <= i_r + 1'b1;
      ph_r <= (4'(ph_r) == nk - 4'd1) ? '0 : ph_r + 1'b1;
      if (ph_r == 3'd0) rc_r <= xtime(rc_r);
    end
    if (!rst_n) busy_r <= 1'b0;
    else if (init) busy_r <= 1'b1;
    else if (busy_r && i_r == 6'd59) busy_r <= 1'b0;
  end
endmodule

// ===== hw/rtl/ackp_front.sv =====
`timescale 1ns / 1ps
module ackp_front import ackp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        init,
  input  logic        accept,
  input  logic [1:0]  kind,
  input  logic [7:0]  data_in,
  input  logic [63:0] skip_amount,
  input  logic [63:0] seek_position,
  input  logic [63:0] iv_low,
  input  logic [4:0]  iv_length,
  output item_t       item
);
  typedef struct packed {
    logic        ok;
    logic [63:0] ctr;
    logic        at_end;
  } shift_t;

  typedef struct packed {
    logic        ok;
    logic        gen;
    logic [63:0] ctr;
    logic [3:0]  off;
    logic        at_end;
  } skip_t;

  logic [63:0] ctr_r, ctr_nxt, ksc_r, ksc_nxt;
  logic [3:0]  off_r, off_nxt;
  logic        ae_r, ae_nxt, ksz_r, ksz_nxt;
  logic [4:0]  il;
  logic [63:0] mask, init_ctr, kept;

  function automatic shift_t shift_ctr(input logic [63:0] ctr, input logic ae,
                                       input logic [63:0] mag, input logic fwd,
                                       input logic [63:0] msk, input logic [63:0] ini);
    shift_t r;
    logic [63:0] idx, room;
    r.ok = 1'b1;
    r.ctr = ctr;
    r.at_end = ae;
    idx = (ctr - ini) & msk;
    room = msk - idx;
    if (mag != '0) begin
      if (fwd) begin
        if (ae || (mag - 64'd1) > room) r.ok = 1'b0;
        else begin
          r.at_end = mag > room;
          r.ctr = (ctr + mag) & msk;
        end
      end else begin
        if (ae ? ((mag - 64'd1) > msk) : (mag > idx)) r.ok = 1'b0;
        else begin
          r.ctr = (ctr - mag) & msk;
          r.at_end = 1'b0;
        end
      end
    end
    return r;
  endfunction

  function automatic skip_t skip_bytes(input logic [63:0] raw, input logic [63:0] ctr,
                                       input logic [3:0] off, input logic ae,
                                       input logic [63:0] msk, input logic [63:0] ini);
    skip_t r;
    shift_t s1, s2;
    logic [63:0] mag, blocks;
    logic [3:0] bytes;
    logic [4:0] bpos;
    logic fail;
    mag = raw[63] ? (64'd0 - raw) : raw;
    blocks = {4'd0, mag[63:4]};
    bytes = mag[3:0];
    r.ok = 1'b0;
    r.gen = 1'b0;
    r.ctr = ctr;
    r.off = off;
    r.at_end = ae;
    fail = 1'b0;
    bpos = 5'(off) + 5'(bytes);
    if (raw[63]) begin
      r.off = off - bytes;
      if (bytes > off) begin
        s1 = shift_ctr(r.ctr, r.at_end, 64'd1, 1'b0, msk, ini);
        if (!s1.ok) fail = 1'b1;
        else begin
          r.ctr = s1.ctr;
          r.at_end = s1.at_end;
        end
      end
      if (!fail) begin
        s2 = shift_ctr(r.ctr, r.at_end, blocks, 1'b0, msk, ini);
        if (!s2.ok) fail = 1'b1;
        else begin
          r.ctr = s2.ctr;
          r.at_end = s2.at_end;
        end
      end
    end else begin
      if (bpos[4]) begin
        s1 = shift_ctr(r.ctr, r.at_end, 64'd1, 1'b1, msk, ini);
        if (!s1.ok) fail = 1'b1;
        else begin
          r.ctr = s1.ctr;
          r.at_end = s1.at_end;
        end
      end
      if (!fail) begin
        s2 = shift_ctr(r.ctr, r.at_end, blocks, 1'b1, msk, ini);
        if (!s2.ok) fail = 1'b1;
        else begin
          r.ctr = s2.ctr;
          r.at_end = s2.at_end;
        end
      end
      if (!fail && r.at_end && bpos[3:0] != 4'd0) fail = 1'b1;
      if (!fail) r.off = bpos[3:0];
    end
    if (!fail) begin
      r.ok = 1'b1;
      r.gen = 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    if (iv_length < 5'd8) il = 5'd8;
    else if (iv_length > 5'd16) il = 5'd16;
    else il = iv_length;
    case (il)
      5'd9:    mask = 64'h00FF_FFFF_FFFF_FFFF;
      5'd10:   mask = 64'h0000_FFFF_FFFF_FFFF;
      5'd11:   mask = 64'h0000_00FF_FFFF_FFFF;
      5'd12:   mask = 64'h0000_0000_FFFF_FFFF;
      5'd13:   mask = 64'h0000_0000_00FF_FFFF;
      5'd14:   mask = 64'h0000_0000_0000_FFFF;
      5'd15:   mask = 64'h0000_0000_0000_00FF;
      default: mask = ALL_ONES;
    endcase
    init_ctr = (il == 5'd16) ? iv_low : 64'd0;
    kept = iv_low & ~mask;
  end

  always_comb begin
    shift_t sh;
    skip_t  sk;
    logic [63:0] lim;
    ctr_nxt = ctr_r;
    off_nxt = off_r;
    ae_nxt  = ae_r;
    ksz_nxt = ksz_r;
    ksc_nxt = ksc_r;
    item.mode = MODE_ZERO;
    item.din  = data_in;
    item.sel  = off_r;
    item.ok   = 1'b0;
    item.ctr  = kept ^ ksc_r;
    lim = (mask + 64'd1) << 4;
    case (kind)
      KIND_PROCESS: begin
        if (off_r == 4'd0) begin
          if (ae_r) begin
            item.mode = MODE_RAW;
          end else begin
            ksz_nxt   = 1'b0;
            ksc_nxt   = ctr_r;
            item.mode = MODE_KS;
            item.ctr  = kept ^ ctr_r;
            off_nxt   = 4'd1;
            item.ok   = 1'b1;
          end
        end else begin
          item.mode = ksz_r ? MODE_RAW : MODE_KS;
          item.ok   = 1'b1;
          off_nxt   = off_r + 4'd1;
          if (off_r == 4'(BLOCK_BYTES - 1)) begin
            sh = shift_ctr(ctr_r, ae_r, 64'd1, 1'b1, mask, init_ctr);
            item.ok = sh.ok;
            ctr_nxt = sh.ctr;
            ae_nxt  = sh.at_end;
          end
        end
      end
      KIND_SKIP: begin
        sk = skip_bytes(skip_amount, ctr_r, off_r, ae_r, mask, init_ctr);
        item.ok = sk.ok;
        ctr_nxt = sk.ctr;
        off_nxt = sk.off;
        ae_nxt  = sk.at_end;
        if (sk.gen) begin
          ksz_nxt = 1'b0;
          ksc_nxt = sk.ctr;
        end
      end
      KIND_SEEK: begin
        if (!seek_position[63] && !(mask != ALL_ONES && seek_position > lim)) begin
          sk = skip_bytes(seek_position, init_ctr, 4'd0, 1'b0, mask, init_ctr);
          item.ok = sk.ok;
          ctr_nxt = sk.ctr;
          off_nxt = sk.off;
          ae_nxt  = sk.at_end;
          ksz_nxt = !sk.gen;
          ksc_nxt = sk.ctr;
        end
      end
      default: begin
      end
    endcase
    item.pos = {ctr_nxt[59:0], off_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r <= '0;
      off_r <= '0;
      ae_r  <= 1'b0;
      ksz_r <= 1'b1;
      ksc_r <= '0;
    end else if (init) begin
      ctr_r <= init_ctr;
      off_r <= '0;
      ae_r  <= 1'b0;
      ksz_r <= 1'b1;
      ksc_r <= '0;
    end else if (accept) begin
      ctr_r <= ctr_nxt;
      off_r <= off_nxt;
      ae_r  <= ae_nxt;
      ksz_r <= ksz_nxt;
      ksc_r <= ksc_nxt;
    end
  end
endmodule

// ===== hw/rtl/ackp_back.sv =====
`timescale 1ns / 1ps
module ackp_back import ackp_pkg::*; #(
  parameter int OUT_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  item_t       item,
  input  logic        item_empty,
  output logic        item_pop,
  input  rk_t         rk,
  input  logic [3:0]  nr,
  input  logic [63:0] iv_high,
  input  logic        res_pop,
  output res_t        res,
  output logic        res_empty
);
  localparam int CW = $clog2(OUT_DEPTH + 1);

  logic          vld_r [15];
  logic [127:0]  st_r  [15];
  item_t         it_r  [15];
  logic [CW-1:0] cnt_r;
  logic          res_full, do_res_pop;
  logic [7:0]    ks;
  res_t          res_in;
  logic [127:0]  sh;

  assign item_pop   = !item_empty && (cnt_r < CW'(OUT_DEPTH));
  assign do_res_pop = res_pop && !res_empty;

  always_ff @(posedge clk) begin
    st_r[0] <= {iv_high, item.ctr} ^ rk[0];
    it_r[0] <= item;
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
      cnt_r    <= '0;
    end else begin
      vld_r[0] <= item_pop;
      cnt_r    <= cnt_r + CW'(item_pop) - CW'(do_res_pop);
    end
  end

  for (genvar k = 1; k < 15; k++) begin : g_rnd
    rnd_t kind;
    always_comb begin
      if (4'(k) < nr) kind = RND_FULL;
      else if (4'(k) == nr) kind = RND_FINAL;
      else kind = RND_PASS;
    end
    always_ff @(posedge clk) begin
      st_r[k] <= aes_round(st_r[k-1], rk[k], kind);
      it_r[k] <= it_r[k-1];
      if (!rst_n) vld_r[k] <= 1'b0;
      else vld_r[k] <= vld_r[k-1];
    end
  end

  always_comb begin
    sh = st_r[14] >> (8 * (15 - int'(it_r[14].sel)));
    ks = sh[7:0];
    case (it_r[14].mode)
      MODE_KS:  res_in.data = ks ^ it_r[14].din;
      MODE_RAW: res_in.data = it_r[14].din;
      default:  res_in.data = 8'h00;
    endcase
    res_in.ok  = it_r[14].ok;
    res_in.pos = it_r[14].pos;
  end

  ackp_fifo #(.WIDTH($bits(res_t)), .DEPTH(OUT_DEPTH)) u_out (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (vld_r[14]),
    .wdata (res_in),
    .full  (res_full),
    .pop   (res_pop),
    .rdata (res),
    .empty (res_empty)
  );

  logic unused_full;
  assign unused_full = res_full;
endmodule

// ===== hw/rtl/aes_ctr_keystream_seekable_unit.sv =====
`timescale 1ns / 1ps
// byte-serial aes counter-mode engine with skip and seek
// input channel: push/full carries kind, data_in, skip_amount, seek_position;
//   one item per cycle is taken while full is low
// result channel: empty/pop shows data_out, ok, position of the oldest item;
//   exactly one result per item, in order
// config channel: cfg_valid/cfg_ready with a register index and 64-bit data;
//   cfg_ready is always high, indices above 7 are dropped
// throughput: one item per cycle while full is low; every item runs a 15-stage pipeline, key
//   whitening then one round per stage, with round keys held in registers
// reset and every config write reload the stream state and rerun the key
//   schedule, one word per cycle, with full held high
// when the receiver stalls, results collect in a 32-entry output queue;
//   issue into the round pipeline stops once pipeline plus queue hold 32,
//   then the 4-entry queue behind the front fills and full rises
module aes_ctr_keystream_seekable_unit import ackp_pkg::*; #(
  parameter int MID_DEPTH = 4,
  parameter int OUT_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [1:0]         in_kind,
  input  logic [7:0]         in_data_in,
  input  logic signed [63:0] in_skip_amount,
  input  logic signed [63:0] in_seek_position,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [7:0]         out_data_out,
  output logic               out_ok,
  output logic [63:0]        out_position,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  logic [63:0] kw_r [4];
  logic [5:0]  key_len_r;
  logic [63:0] iv_high_r, iv_low_r;
  logic [4:0]  iv_len_r;
  logic        init_r, cfg_wr, accept, busy, mid_full, mid_empty, mid_pop;
  item_t       item_new, item_head;
  rk_t         rk;
  logic [3:0]  nr;
  res_t        res;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready && (cfg_index <= REG_IV_LN);
  assign in_full   = init_r || busy || mid_full;
  assign accept    = in_push && !in_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < 4; j++) kw_r[j] <= '0;
      key_len_r <= 6'd16;
      iv_high_r <= '0;
      iv_low_r  <= '0;
      iv_len_r  <= 5'd16;
      init_r    <= 1'b1;
    end else begin
      init_r <= cfg_wr;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KEY_0:  kw_r[0]   <= cfg_data;
          REG_KEY_1:  kw_r[1]   <= cfg_data;
          REG_KEY_2:  kw_r[2]   <= cfg_data;
          REG_KEY_3:  kw_r[3]   <= cfg_data;
          REG_KEY_LN: key_len_r <= cfg_data[5:0];
          REG_IV_HI:  iv_high_r <= cfg_data;
          REG_IV_LO:  iv_low_r  <= cfg_data;
          REG_IV_LN:  iv_len_r  <= cfg_data[4:0];
          default: begin
          end
        endcase
      end
    end
  end

  ackp_key u_key (
    .clk        (clk),
    .rst_n      (rst_n),
    .init       (init_r),
    .key        ({kw_r[0], kw_r[1], kw_r[2], kw_r[3]}),
    .key_length (key_len_r),
    .rk         (rk),
    .nr         (nr),
    .busy       (busy)
  );

  ackp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .init          (init_r),
    .accept        (accept),
    .kind          (in_kind),
    .data_in       (in_data_in),
    .skip_amount   (in_skip_amount),
    .seek_position (in_seek_position),
    .iv_low        (iv_low_r),
    .iv_length     (iv_len_r),
    .item          (item_new)
  );

  ackp_fifo #(.WIDTH($bits(item_t)), .DEPTH(MID_DEPTH)) u_mid (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept),
    .wdata (item_new),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (item_head),
    .empty (mid_empty)
  );

  ackp_back #(.OUT_DEPTH(OUT_DEPTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item_head),
    .item_empty (mid_empty),
    .item_pop   (mid_pop),
    .rk         (rk),
    .nr         (nr),
    .iv_high    (iv_high_r),
    .res_pop    (out_pop),
    .res        (res),
    .res_empty  (out_empty)
  );

  assign out_data_out = res.data;
  assign out_ok       = res.ok;
  assign out_position = res.pos;

  a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> in_full) else $error("item taken right after a config write");

  a_rst_blocks: assert property (@(posedge clk)
    !rst_n |=> in_full) else $error("item taken right after reset");

  a_init_busy: assert property (@(posedge clk) disable iff (!rst_n)
    init_r |=> busy) else $error("key schedule did not start");
endmodule
